### hdl/crfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crfc_pkg;

    // field and datapath widths
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int TIME_W      = 16;
    localparam int TPM_W       = 16;
    localparam int RELOAD_W    = 2;
    localparam int HOLD_W      = 3;
    localparam int RATE_W      = 32;
    localparam int STAT_W      = 31;
    localparam int SUM_W       = 64;
    localparam int PROD_W      = 48;
    localparam int DIV_NUM_W   = 64;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_CNT_W   = 7;

    // divider step counts: rate numerator is pre-shifted so 48 steps suffice
    localparam logic [DIV_CNT_W-1:0] RATE_STEPS = 7'd48;
    localparam logic [DIV_CNT_W-1:0] AVG_STEPS  = 7'd64;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_MINUTE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_RELOAD      = 1'd1;

    localparam logic [TPM_W-1:0]    TPM_RESET    = 16'd60000;
    localparam logic [RELOAD_W-1:0] RELOAD_RESET = 2'd3;

    // flag bit positions
    localparam int FLAG_WHEEL = 0;
    localparam int FLAG_CRANK = 1;

    typedef struct packed {
        logic                        start;
        logic [DIV_NUM_W-1:0]        num;
        logic [DIV_DEN_W-1:0]        den;
        logic [DIV_CNT_W-1:0]        steps;
    } div_req_t;

    typedef struct packed {
        logic                        busy;
        logic                        done;
        logic [DIV_NUM_W-1:0]        quot;
    } div_rsp_t;

endpackage

`default_nettype wire

### hdl/cadence_rate_from_counters_top.sv
`timescale 1ns / 1ps
`default_nettype none

// cadence / speed rate from cumulative revolution counters
// input channel (in_valid / in_ready): one measurement record per transaction,
//   a flags byte and six little-endian payload bytes
// output channel (out_valid / out_ready): one result per record, carrying the
//   signed rate in revolutions per minute, the mean of all positive rates and
//   the peak rate
// configuration: cfg_we writes cfg_data into register cfg_index
//   (0 ticks_per_minute, 1 hold_reload); write only while the block is idle
// one record is worked on at a time; in_ready is high only in the idle state
// a record with a new event divides for the rate on the shared restoring
//   divider (48 steps); a record whose current rate is positive also divides
//   for the mean (64 steps) unless the sample count is full; a record with
//   neither skips the divider
// a finished result sits in the output register; a new record is accepted
//   while it waits, and the block holds its next result until the receiver
//   takes the previous one
// reset clears all running state and loads ticks_per_minute = 60000 and
//   hold_reload = 3
module cadence_rate_from_counters_top
(
    input  wire                                     clk,
    input  wire                                     rst_n,

    input  wire                                     in_valid,
    output logic                                    in_ready,
    input  wire  [crfc_pkg::BYTE_W-1:0]             flags,
    input  wire  [crfc_pkg::BYTE_W-1:0]             byte1,
    input  wire  [crfc_pkg::BYTE_W-1:0]             byte2,
    input  wire  [crfc_pkg::BYTE_W-1:0]             byte3,
    input  wire  [crfc_pkg::BYTE_W-1:0]             byte4,
    input  wire  [crfc_pkg::BYTE_W-1:0]             byte5,
    input  wire  [crfc_pkg::BYTE_W-1:0]             byte6,

    output logic                                    out_valid,
    input  wire                                     out_ready,
    output logic signed [crfc_pkg::RATE_W-1:0]      rate,
    output logic [crfc_pkg::STAT_W-1:0]             average_rate,
    output logic [crfc_pkg::STAT_W-1:0]             peak_rate,

    input  wire                                     cfg_we,
    input  wire  [crfc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [crfc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,   // waiting for a record
        S_PREP  = 9'b000000010,   // count and time differences
        S_MUL   = 9'b000000100,   // count difference times scale
        S_RDIV  = 9'b000001000,   // launch rate division
        S_RWAIT = 9'b000010000,   // rate division running
        S_SAT   = 9'b000100000,   // sign and saturate the quotient
        S_ACCUM = 9'b001000000,   // running sum, sample count, peak
        S_AWAIT = 9'b010000000,   // mean division running
        S_OUT   = 9'b100000000    // hand result to the output register
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [crfc_pkg::TPM_W-1:0]    tpm_reg, tpm_next;
    logic [crfc_pkg::RELOAD_W-1:0] reload_reg, reload_next;

    // running state
    logic [crfc_pkg::COUNT_W-1:0]        last_count_reg, last_count_next;
    logic [crfc_pkg::TIME_W-1:0]         last_time_reg, last_time_next;
    logic signed [crfc_pkg::HOLD_W-1:0]  hold_reg, hold_next;
    logic signed [crfc_pkg::RATE_W-1:0]  cur_rate_reg, cur_rate_next;
    logic [crfc_pkg::SUM_W-1:0]          sum_reg, sum_next;
    logic [crfc_pkg::COUNT_W-1:0]        samples_reg, samples_next;
    logic [crfc_pkg::STAT_W-1:0]         peak_reg, peak_next;
    logic [crfc_pkg::STAT_W-1:0]         avg_reg, avg_next;

    // per-record working registers
    logic [crfc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [crfc_pkg::TIME_W-1:0]  time_reg, time_next;
    logic [crfc_pkg::TIME_W-1:0]  dt_reg, dt_next;
    logic [crfc_pkg::COUNT_W-1:0] mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic [crfc_pkg::PROD_W-1:0]  prod_reg, prod_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic signed [crfc_pkg::RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic [crfc_pkg::STAT_W-1:0]         out_avg_reg, out_avg_next;
    logic [crfc_pkg::STAT_W-1:0]         out_peak_reg, out_peak_next;

    // shared divider
    crfc_pkg::div_req_t div_req;
    crfc_pkg::div_rsp_t div_rsp;

    logic                         in_fire;
    logic [crfc_pkg::COUNT_W-1:0] dc_raw;
    logic [crfc_pkg::COUNT_W-1:0] dc_inv;
    logic [crfc_pkg::TIME_W-1:0]  dt_raw;
    logic signed [crfc_pkg::HOLD_W-1:0] hold_dec;
    logic [crfc_pkg::PROD_W-1:0]  q_mag;
    logic                         q_over_pos;
    logic                         q_over_neg;
    logic                         rate_pos;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // differences against the stored reference point
    assign dc_raw = count_reg - last_count_reg;
    assign dc_inv = last_count_reg - count_reg;
    assign dt_raw = time_reg - last_time_reg;

    // hold counter stops at minus one
    assign hold_dec = (hold_reg == -3'sd1) ? hold_reg : hold_reg - 3'sd1;

    // quotient magnitude and its saturation limits
    assign q_mag      = div_rsp.quot[crfc_pkg::PROD_W-1:0];
    assign q_over_pos = |q_mag[crfc_pkg::PROD_W-1:crfc_pkg::RATE_W-1];
    assign q_over_neg = (|q_mag[crfc_pkg::PROD_W-1:crfc_pkg::RATE_W])
                        || (q_mag[crfc_pkg::RATE_W-1]
                            && (|q_mag[crfc_pkg::RATE_W-2:0]));

    assign rate_pos = !cur_rate_reg[crfc_pkg::RATE_W-1] && (cur_rate_reg != '0);

    crfc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        tpm_next        = tpm_reg;
        reload_next     = reload_reg;
        last_count_next = last_count_reg;
        last_time_next  = last_time_reg;
        hold_next       = hold_reg;
        cur_rate_next   = cur_rate_reg;
        sum_next        = sum_reg;
        samples_next    = samples_reg;
        peak_next       = peak_reg;
        avg_next        = avg_reg;
        count_next      = count_reg;
        time_next       = time_reg;
        dt_next         = dt_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg;
        out_rate_next   = out_rate_reg;
        out_avg_next    = out_avg_reg;
        out_peak_next   = out_peak_reg;

        div_req.start = 1'b0;
        div_req.num   = {prod_reg, {(crfc_pkg::DIV_NUM_W-crfc_pkg::PROD_W){1'b0}}};
        div_req.den   = {{(crfc_pkg::DIV_DEN_W-crfc_pkg::TIME_W){1'b0}}, dt_reg};
        div_req.steps = crfc_pkg::RATE_STEPS;

        // receiver takes the waiting result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // register writes, unknown index ignored
        if (cfg_we)
        begin
            case (cfg_index)
                crfc_pkg::REG_TICKS_PER_MINUTE:
                    tpm_next = cfg_data[crfc_pkg::TPM_W-1:0];
                crfc_pkg::REG_HOLD_RELOAD:
                    reload_next = cfg_data[crfc_pkg::RELOAD_W-1:0];
                default:
                    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // wheel data wins over crank data; neither gives zeros
                    if (flags[crfc_pkg::FLAG_WHEEL])
                    begin
                        count_next = {byte4, byte3, byte2, byte1};
                        time_next  = {byte6, byte5};
                    end
                    else if (flags[crfc_pkg::FLAG_CRANK])
                    begin
                        count_next = {16'd0, byte2, byte1};
                        time_next  = {byte4, byte3};
                    end
                    else
                    begin
                        count_next = '0;
                        time_next  = '0;
                    end
                    state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                dt_next  = dt_raw;
                neg_next = dc_raw[crfc_pkg::COUNT_W-1];
                mag_next = dc_raw[crfc_pkg::COUNT_W-1] ? dc_inv : dc_raw;
                if (dt_raw != '0)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    // no new event: count down the hold
                    hold_next = hold_dec;
                    if (hold_dec <= 3'sd0)
                    begin
                        cur_rate_next = '0;
                    end
                    if (hold_dec == 3'sd0)
                    begin
                        last_count_next = count_reg;
                        last_time_next  = time_reg;
                    end
                    state_next = S_ACCUM;
                end
            end

            S_MUL:
            begin
                prod_next  = crfc_pkg::PROD_W'(mag_reg) * crfc_pkg::PROD_W'(tpm_reg);
                hold_next  = crfc_pkg::HOLD_W'({1'b0, reload_reg});
                state_next = S_RDIV;
            end

            S_RDIV:
            begin
                div_req.start = 1'b1;
                state_next    = S_RWAIT;
            end

            S_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SAT;
                end
            end

            S_SAT:
            begin
                if (!neg_reg)
                begin
                    cur_rate_next = q_over_pos ? 32'sh7FFFFFFF
                                               : $signed({1'b0, q_mag[crfc_pkg::RATE_W-2:0]});
                end
                else
                begin
                    cur_rate_next = q_over_neg ? 32'sh80000000
                                               : -$signed(q_mag[crfc_pkg::RATE_W-1:0]);
                end
                last_count_next = count_reg;
                last_time_next  = time_reg;
                state_next      = S_ACCUM;
            end

            S_ACCUM:
            begin
                if (rate_pos && (cur_rate_reg[crfc_pkg::STAT_W-1:0] > peak_reg))
                begin
                    peak_next = cur_rate_reg[crfc_pkg::STAT_W-1:0];
                end
                if (rate_pos && (samples_reg != '1))
                begin
                    sum_next     = sum_reg + crfc_pkg::SUM_W'(cur_rate_reg[crfc_pkg::STAT_W-1:0]);
                    samples_next = samples_reg + 1'b1;
                    // mean changes only here, recompute it
                    div_req.start = 1'b1;
                    div_req.num   = sum_next;
                    div_req.den   = samples_next;
                    div_req.steps = crfc_pkg::AVG_STEPS;
                    state_next    = S_AWAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_AWAIT:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quot[crfc_pkg::STAT_W-1:0];
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = cur_rate_reg;
                    out_avg_next   = avg_reg;
                    out_peak_next  = peak_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tpm_reg        <= crfc_pkg::TPM_RESET;
            reload_reg     <= crfc_pkg::RELOAD_RESET;
            last_count_reg <= '0;
            last_time_reg  <= '0;
            hold_reg       <= '0;
            cur_rate_reg   <= '0;
            sum_reg        <= '0;
            samples_reg    <= '0;
            peak_reg       <= '0;
            avg_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tpm_reg        <= tpm_next;
            reload_reg     <= reload_next;
            last_count_reg <= last_count_next;
            last_time_reg  <= last_time_next;
            hold_reg       <= hold_next;
            cur_rate_reg   <= cur_rate_next;
            sum_reg        <= sum_next;
            samples_reg    <= samples_next;
            peak_reg       <= peak_next;
            avg_reg        <= avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        count_reg    <= count_next;
        time_reg     <= time_next;
        dt_reg       <= dt_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        out_rate_reg <= out_rate_next;
        out_avg_reg  <= out_avg_next;
        out_peak_reg <= out_peak_next;
    end

    assign out_valid    = out_valid_reg;
    assign rate         = out_rate_reg;
    assign average_rate = out_avg_reg;
    assign peak_rate    = out_peak_reg;

    // divider is never relaunched while a division is running
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider launched while busy");

    // hold counter never drops below minus one
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg[crfc_pkg::HOLD_W-1] |-> (hold_reg == -3'sd1))
        else $error("hold counter out of range");

    // the mean of positive rates never exceeds the peak
    a_avg_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        avg_reg <= peak_reg)
        else $error("mean above peak");

    // an accepted record always starts the difference step next
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_PREP))
        else $error("accepted record not processed");

endmodule

`default_nettype wire

### hdl/crfc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// shared restoring divider, one quotient bit per cycle
module crfc_div
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire crfc_pkg::div_req_t req,
    output crfc_pkg::div_rsp_t   rsp
);

    logic [crfc_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [crfc_pkg::DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [crfc_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [crfc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [crfc_pkg::DIV_DEN_W:0]   shifted;
    logic [crfc_pkg::DIV_DEN_W:0]   diff;
    logic                           ge;

    assign shifted = {rem_reg, quo_reg[crfc_pkg::DIV_NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            den_next  = req.den;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[crfc_pkg::DIV_DEN_W-1:0]
                          : shifted[crfc_pkg::DIV_DEN_W-1:0];
            quo_next = {quo_reg[crfc_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == crfc_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

`default_nettype wire

### sim/crfc_rate_checker.sv
`timescale 1ns / 1ps

module crfc_rate_checker
    import crfc_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          in_valid,
    input  wire                          in_ready,
    input  wire  [BYTE_W-1:0]            flags,
    input  wire  [BYTE_W-1:0]            byte1,
    input  wire  [BYTE_W-1:0]            byte2,
    input  wire  [BYTE_W-1:0]            byte3,
    input  wire  [BYTE_W-1:0]            byte4,
    input  wire  [BYTE_W-1:0]            byte5,
    input  wire  [BYTE_W-1:0]            byte6,

    input  wire                          out_valid,
    input  wire                          out_ready,
    input  wire  signed [RATE_W-1:0]     rate,
    input  wire  [STAT_W-1:0]            average_rate,
    input  wire  [STAT_W-1:0]            peak_rate,

    input  wire                          cfg_we,
    input  wire  [CFG_INDEX_W-1:0]       cfg_index,
    input  wire  [CFG_DATA_W-1:0]        cfg_data,

    output int                           mismatches,
    output int                           outstanding,
    output int                           results_seen
);

    typedef struct packed {
        logic signed [RATE_W-1:0] rate;
        logic [STAT_W-1:0]        average;
        logic [STAT_W-1:0]        peak;
    } cadence_result_t;

    cadence_result_t          expected_results[$];

    logic [TPM_W-1:0]         tpm_cfg;
    logic [RELOAD_W-1:0]      reload_cfg;

    logic [COUNT_W-1:0]       prev_count;
    logic [TIME_W-1:0]        prev_time;
    logic signed [HOLD_W-1:0] hold_cnt;
    logic signed [RATE_W-1:0] rate_now;
    logic [SUM_W-1:0]         sum_acc;
    logic [31:0]              sum_samples;
    logic signed [RATE_W-1:0] peak_now;

    int                       err_count;
    int                       got_count;

    // expected result of one record, advancing the running state
    function automatic cadence_result_t predict_record(
        input logic [BYTE_W-1:0] f,
        input logic [BYTE_W-1:0] b1,
        input logic [BYTE_W-1:0] b2,
        input logic [BYTE_W-1:0] b3,
        input logic [BYTE_W-1:0] b4,
        input logic [BYTE_W-1:0] b5,
        input logic [BYTE_W-1:0] b6
    );
        cadence_result_t  res;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  tm;
        logic [COUNT_W-1:0] dc;
        logic [TIME_W-1:0]  dt;
        longint             num;
        longint             quo;
        logic [SUM_W-1:0]   avg;
        cnt = '0;
        tm  = '0;
        if (f[FLAG_WHEEL]) begin
            cnt = {b4, b3, b2, b1};
            tm  = {b6, b5};
        end else if (f[FLAG_CRANK]) begin
            cnt = {16'd0, b2, b1};
            tm  = {b4, b3};
        end
        dc = cnt - prev_count;
        dt = tm - prev_time;
        if (dt != '0) begin
            num = longint'($signed(dc)) * longint'({48'd0, tpm_cfg});
            quo = num / longint'({48'd0, dt});
            if (quo > 64'sh0000_0000_7FFF_FFFF)
                rate_now = 32'sh7FFF_FFFF;
            else if (quo < -64'sh0000_0000_8000_0000)
                rate_now = 32'sh8000_0000;
            else
                rate_now = quo[RATE_W-1:0];
            hold_cnt = $signed({1'b0, reload_cfg});
        end else begin
            if (hold_cnt > -1)
                hold_cnt = hold_cnt - 1;
            if (hold_cnt <= 0)
                rate_now = '0;
        end
        if (dt != '0 || hold_cnt == 0) begin
            prev_count = cnt;
            prev_time  = tm;
        end
        if (rate_now > 0 && sum_samples != 32'hFFFF_FFFF) begin
            sum_acc     = sum_acc + {32'd0, rate_now};
            sum_samples = sum_samples + 32'd1;
        end
        avg = '0;
        if (sum_samples != '0)
            avg = sum_acc / {32'd0, sum_samples};
        if (rate_now > peak_now)
            peak_now = rate_now;
        res.rate    = rate_now;
        res.average = avg[STAT_W-1:0];
        res.peak    = peak_now[STAT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        cadence_result_t exp_r;
        cadence_result_t new_r;
        if (!rst_n) begin
            tpm_cfg     = TPM_RESET;
            reload_cfg  = RELOAD_RESET;
            prev_count  = '0;
            prev_time   = '0;
            hold_cnt    = '0;
            rate_now    = '0;
            sum_acc     = '0;
            sum_samples = '0;
            peak_now    = '0;
            err_count   = 0;
            got_count   = 0;
            expected_results.delete();
            mismatches   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TICKS_PER_MINUTE)
                    tpm_cfg = cfg_data[TPM_W-1:0];
                else if (cfg_index == REG_HOLD_RELOAD)
                    reload_cfg = cfg_data[RELOAD_W-1:0];
            end
            // results first: a result never belongs to a record taken at the same edge
            if (out_valid && out_ready) begin
                got_count++;
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("result with nothing pending: rate %0d avg %0d peak %0d",
                                 rate, average_rate, peak_rate);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (rate !== exp_r.rate || average_rate !== exp_r.average ||
                        peak_rate !== exp_r.peak) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("result %0d: expected rate %0d avg %0d peak %0d, %s %0d %0d %0d",
                                     got_count, exp_r.rate, exp_r.average, exp_r.peak,
                                     "got", rate, average_rate, peak_rate);
                    end
                end
            end
            if (in_valid && in_ready) begin
                new_r = predict_record(flags, byte1, byte2, byte3, byte4, byte5, byte6);
                expected_results.insert(expected_results.size(), new_r);
            end
            mismatches   <= err_count;
            outstanding  <= expected_results.size();
            results_seen <= got_count;
        end
    end

endmodule

### sim/cadence_rate_from_counters_top_tb.sv
`timescale 1ns / 1ps

module cadence_rate_from_counters_top_tb;

    import crfc_pkg::*;

    // one measurement record as it goes on the input channel
    typedef struct packed {
        logic [BYTE_W-1:0] f;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b3;
        logic [BYTE_W-1:0] b4;
        logic [BYTE_W-1:0] b5;
        logic [BYTE_W-1:0] b6;
    } record_t;

    // receiver behaviour, changed from phase to phase
    typedef enum int {
        RX_FREE,
        RX_HALF,
        RX_SLOW,
        RX_BURSTY
    } rx_mode_t;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_RECORDS  = 300;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;

    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [BYTE_W-1:0]           flags = '0;
    logic [BYTE_W-1:0]           byte1 = '0;
    logic [BYTE_W-1:0]           byte2 = '0;
    logic [BYTE_W-1:0]           byte3 = '0;
    logic [BYTE_W-1:0]           byte4 = '0;
    logic [BYTE_W-1:0]           byte5 = '0;
    logic [BYTE_W-1:0]           byte6 = '0;

    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [RATE_W-1:0]    rate;
    logic [STAT_W-1:0]           average_rate;
    logic [STAT_W-1:0]           peak_rate;

    logic                        cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    int                          mismatches;
    int                          outstanding;
    int                          results_seen;

    // sender bookkeeping
    int                          burst_left = 0;
    bit                          sender_gaps = 1'b1;
    int                          records_sent = 0;
    int                          cfg_writes = 0;
    record_t                     last_rec = '0;

    // simulated sensor: wheel and crank cumulative counts with their event times
    logic [COUNT_W-1:0]          whl_cnt = 32'h0000_2F20;
    logic [TIME_W-1:0]           whl_time = 16'h9000;
    logic [15:0]                 crk_cnt = 16'h0000;
    logic [TIME_W-1:0]           crk_time = 16'h0000;

    // receiver bookkeeping
    rx_mode_t                    rx_mode = RX_FREE;
    int                          rx_phase_left = 0;
    int                          rx_stall = 0;

    always #5 clk = ~clk;

    cadence_rate_from_counters_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .flags        (flags),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3),
        .byte4        (byte4),
        .byte5        (byte5),
        .byte6        (byte6),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rate         (rate),
        .average_rate (average_rate),
        .peak_rate    (peak_rate),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // prediction and comparison live in the checker, beside the block
    crfc_rate_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .flags        (flags),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3),
        .byte4        (byte4),
        .byte5        (byte5),
        .byte6        (byte6),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rate         (rate),
        .average_rate (average_rate),
        .peak_rate    (peak_rate),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // wheel record: 32-bit count in bytes 1..4, time in bytes 5..6
    function automatic record_t wheel_rec(input logic [COUNT_W-1:0] c,
                                          input logic [TIME_W-1:0] t,
                                          input logic [BYTE_W-1:0] fl);
        return {fl, c[7:0], c[15:8], c[23:16], c[31:24], t[7:0], t[15:8]};
    endfunction

    // crank record: 16-bit count in bytes 1..2, time in bytes 3..4, rest is filler
    function automatic record_t crank_rec(input logic [15:0] c,
                                          input logic [TIME_W-1:0] t,
                                          input logic [BYTE_W-1:0] fl,
                                          input logic [15:0] junk);
        return {fl, c[7:0], c[15:8], t[7:0], t[15:8], junk[7:0], junk[15:8]};
    endfunction

    // one random record, mostly a plausible sensor stream with some noise mixed in
    function automatic record_t next_record();
        record_t r;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // wheel event, sometimes no new revolution; flag bit1 random so both can be set
            if ($urandom_range(0, 4) != 0) begin
                whl_cnt  = whl_cnt + $urandom_range(0, 6);
                whl_time = whl_time + 16'($urandom_range(1, 4000));
            end
            r = wheel_rec(whl_cnt, whl_time, (8'($urandom) & 8'hFE) | 8'h01);
        end else if (pick < 70) begin
            if ($urandom_range(0, 4) != 0) begin
                crk_cnt  = crk_cnt + 16'($urandom_range(0, 3));
                crk_time = crk_time + 16'($urandom_range(1, 2000));
            end
            r = crank_rec(crk_cnt, crk_time, (8'($urandom) & 8'hFC) | 8'h02, 16'($urandom));
        end else if (pick < 78) begin
            // no data flags: count and time read as zero
            r = {8'($urandom) & 8'hFC, 48'({$urandom, $urandom})};
        end else if (pick < 86) begin
            r = 56'({$urandom, $urandom});
        end else if (pick < 93) begin
            // counter stepping backwards
            whl_cnt  = whl_cnt - $urandom_range(1, 1000);
            whl_time = whl_time + 16'($urandom_range(1, 100));
            r = wheel_rec(whl_cnt, whl_time, 8'h01);
        end else begin
            // large jump over a short time, drives the rate towards saturation
            whl_cnt  = whl_cnt + $urandom;
            whl_time = whl_time + 16'($urandom_range(1, 3));
            r = wheel_rec(whl_cnt, whl_time, 8'h01);
        end
        return r;
    endfunction

    // present one record and hold it until the transaction completes
    task automatic send_record(input record_t r);
        int gap;
        if (burst_left == 0) begin
            gap = sender_gaps ? $urandom_range(0, 20) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        in_valid <= 1'b1;
        {flags, byte1, byte2, byte3, byte4, byte5, byte6} <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_rec = r;
        records_sent++;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // single register write, then a wait with the write enable low
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    // receiver: ready pattern of its own, from always ready to long stalls
    always @(posedge clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = rx_mode_t'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(50, 400);
        end
        rx_phase_left--;
        case (rx_mode)
            RX_FREE: out_ready <= 1'b1;
            RX_HALF: out_ready <= 1'($urandom_range(0, 1));
            RX_SLOW: out_ready <= ($urandom_range(0, 4) == 0);
            default:
            begin
                if (rx_stall > 0) begin
                    rx_stall--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_stall = $urandom_range(5, 24);
                end
            end
        endcase
    end

    // stimulus and verdict
    initial begin : stimulus
        int reps;
        int p;
        int n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset configuration: one event, then repeats run the hold out past zero
        send_record(wheel_rec(32'h0000_0010, 16'h0400, 8'h01));
        repeat (4) send_record(last_rec);
        // crank extremes; the step back to zero over one tick saturates negative
        send_record(crank_rec(16'hFFFF, 16'hFFFF, 8'h02, 16'h0000));
        send_record(crank_rec(16'h0000, 16'h0000, 8'h02, 16'hFFFF));
        // both flag bits: wheel data wins
        send_record(wheel_rec(32'h0000_0100, 16'h0010, 8'h03));
        // no data flags with all payload bits set
        send_record({8'hFC, 48'hFFFF_FFFF_FFFF});
        // largest positive and most negative count difference over one tick
        send_record(wheel_rec(32'h7FFF_FFFF, 16'h0001, 8'h01));
        send_record(wheel_rec(32'hFFFF_FFFF, 16'h0002, 8'h01));
        // every bit set, then every bit clear
        send_record({8'hFF, 48'hFFFF_FFFF_FFFF});
        send_record('0);
        // counter going backwards
        send_record(wheel_rec(32'h0000_1000, 16'd100, 8'h01));
        send_record(wheel_rec(32'h0000_0F00, 16'd200, 8'h01));

        // scale of zero and reload of zero; upper data bits must be ignored for the reload
        drain_results();
        write_reg(REG_TICKS_PER_MINUTE, 16'd0);
        write_reg(REG_HOLD_RELOAD, 16'hFFFC);
        send_record(wheel_rec(32'h0000_0F10, 16'd300, 8'h01));
        repeat (2) send_record(last_rec);

        // largest scale with a hold reload of one
        drain_results();
        write_reg(REG_TICKS_PER_MINUTE, 16'hFFFF);
        write_reg(REG_HOLD_RELOAD, 16'h0005);
        send_record(wheel_rec(32'h0000_2F10, 16'd301, 8'h01));
        send_record(last_rec);
        send_record(wheel_rec(32'h0000_2F11, 16'h812D, 8'h01));

        // smallest nonzero scale
        drain_results();
        write_reg(REG_TICKS_PER_MINUTE, 16'd1);
        write_reg(REG_HOLD_RELOAD, 16'd2);
        send_record(wheel_rec(32'h0000_2F20, 16'h9000, 8'h01));
        send_record(last_rec);

        // random phases, each with its own configuration written while idle
        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case (p)
                0: write_reg(REG_TICKS_PER_MINUTE, 16'hFFFF);
                1: write_reg(REG_TICKS_PER_MINUTE, 16'd1);
                RANDOM_PHASES - 1: write_reg(REG_TICKS_PER_MINUTE, TPM_RESET);
                default: write_reg(REG_TICKS_PER_MINUTE, 16'($urandom_range(1, 65535)));
            endcase
            write_reg(REG_HOLD_RELOAD, {14'($urandom), 2'(p % 4)});
            // one phase with no random gaps from the sender
            sender_gaps = (p != 3);
            n = 0;
            while (n < PHASE_RECORDS) begin
                if ($urandom_range(0, 6) == 0) begin
                    // runs of records with no new event walk the hold counter down
                    reps = $urandom_range(1, 5);
                    repeat (reps) send_record(last_rec);
                    n += reps;
                end else begin
                    send_record(next_record());
                    n++;
                end
                // now and then let the block run dry mid-phase
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end

        drain_results();
        // allow for the longest latency in case a stray transaction follows
        repeat (150) @(posedge clk);

        $display("covered %0d records and %0d results, %0d register writes,", records_sent,
                 results_seen, cfg_writes);
        $display("including saturation, hold run-out and the scale and reload extremes");
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
